// ----- rtl/core/t2a_pkg.sv -----
// Types and encoding constants for the Thumb-to-ARM decompressor.
`default_nettype none
package t2a_pkg;

	// Input beat: format selector and raw Thumb halfword
	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] thumb_halfword;
	} t2a_in_t;

	// Result beat: ARM encoding and its class
	typedef struct packed {
		logic [31:0] arm_word;
		logic [1:0]  instr_class;
	} t2a_out_t;

	// Format selector codes
	localparam logic [2:0] FMT_SHIFT_IMM = 3'd0;
	localparam logic [2:0] FMT_ADD_SUB   = 3'd1;
	localparam logic [2:0] FMT_IMM_OPS   = 3'd2;
	localparam logic [2:0] FMT_ALU       = 3'd3;
	localparam logic [2:0] FMT_HIREG     = 3'd4;
	localparam logic [2:0] FMT_BCOND     = 3'd5;
	localparam logic [2:0] FMT_BAL       = 3'd6;

	// Instruction class codes
	localparam logic [1:0] CLS_DP     = 2'd0;
	localparam logic [1:0] CLS_MUL    = 2'd1;
	localparam logic [1:0] CLS_BX     = 2'd2;
	localparam logic [1:0] CLS_BRANCH = 2'd3;

	// ARM base encodings
	localparam logic [31:0] BASE_DP_REG_S = 32'hE010_0000;
	localparam logic [31:0] BASE_DP_IMM_S = 32'hE210_0000;
	localparam logic [31:0] BASE_DP_REG   = 32'hE000_0000;
	localparam logic [31:0] BASE_BX       = 32'hE12F_FF10;
	localparam logic [3:0]  BCOND_OP      = 4'hA;
	localparam logic [7:0]  BAL_TOP       = 8'hEA;

	// ARM data-processing opcodes
	localparam logic [3:0] DP_ADD = 4'h4;
	localparam logic [3:0] DP_SUB = 4'h2;
	localparam logic [3:0] DP_RSB = 4'h3;
	localparam logic [3:0] DP_CMP = 4'hA;
	localparam logic [3:0] DP_MOV = 4'hD;

	// Thumb ALU sub-opcodes that need rewriting
	localparam logic [3:0] ALU_LSL = 4'h2;
	localparam logic [3:0] ALU_LSR = 4'h3;
	localparam logic [3:0] ALU_ASR = 4'h4;
	localparam logic [3:0] ALU_NEG = 4'h9;
	localparam logic [3:0] ALU_MUL = 4'hD;
	localparam logic [3:0] ALU_ROR = 4'h7;

	// Hi-register sub-opcodes
	localparam logic [1:0] HI_ADD = 2'd0;
	localparam logic [1:0] HI_CMP = 2'd1;
	localparam logic [1:0] HI_MOV = 2'd2;

	// Shift types and multiply marker bits
	localparam logic [1:0] SH_LSL = 2'd0;
	localparam logic [1:0] SH_LSR = 2'd1;
	localparam logic [1:0] SH_ASR = 2'd2;
	localparam logic [1:0] SH_ROR = 2'd3;
	localparam logic [3:0] MUL_MARK = 4'h9;

	// Immediate-format opcode map: MOV, CMP, ADD, SUB
	localparam logic [3:0] IMM_OPS [4] = '{DP_MOV, DP_CMP, DP_ADD, DP_SUB};

endpackage
`default_nettype wire

// ----- rtl/core/thumb_to_arm_decompress_top.sv -----
// Thumb-to-ARM decompressor: input register, decode logic, result register.
// The halfword is registered in in_s1, decoded, and the ARM word registered in out_s2.
// Throughput: one beat per cycle; busy is always low, decode has no loops.
// The receiver cannot stall; done pulses for one cycle with each result.
// Reset clears the valid flags only; payload registers are not reset.
`default_nettype none
module thumb_to_arm_decompress_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire t2a_pkg::t2a_in_t  src,
	output logic                   done,
	output t2a_pkg::t2a_out_t      res
);
	import t2a_pkg::*;

	logic     vld_s1;
	t2a_in_t  in_s1;
	logic     vld_s2;
	t2a_out_t out_s2;
	t2a_out_t dec;

	// No stall source: a beat can enter every cycle
	assign busy = 1'b0;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (start) begin
			in_s1 <= src;
		end
		if (vld_s1) begin
			out_s2 <= dec;
		end
	end

	// Decode one halfword
	always_comb begin
		logic [15:0] t;
		logic [2:0]  rd3;
		logic [2:0]  rs3;
		logic [3:0]  rd4;
		logic [3:0]  rs4;
		logic [3:0]  aop;
		logic [1:0]  sh;
		logic        is_shift;
		logic [31:0] w;
		logic [1:0]  cls;

		t   = in_s1.thumb_halfword;
		w   = '0;
		cls = CLS_DP;
		rd3 = t[2:0];
		rs3 = t[5:3];
		rd4 = {t[7], t[2:0]};
		rs4 = {t[6], t[5:3]};
		aop = t[9:6];
		sh  = SH_LSL;
		is_shift = 1'b0;

		case (in_s1.opcode)
			FMT_SHIFT_IMM: begin
				w        = BASE_DP_REG_S;
				w[24:21] = DP_MOV;
				w[15:12] = {1'b0, rd3};
				w[11:7]  = t[10:6];
				w[6:5]   = t[12:11];
				w[3:0]   = {1'b0, rs3};
			end
			FMT_ADD_SUB: begin
				w        = BASE_DP_REG_S;
				w[25]    = t[10];
				w[24:21] = t[9] ? DP_SUB : DP_ADD;
				w[19:16] = {1'b0, rs3};
				w[15:12] = {1'b0, rd3};
				w[3:0]   = {1'b0, t[8:6]};
			end
			FMT_IMM_OPS: begin
				w        = BASE_DP_IMM_S;
				w[24:21] = IMM_OPS[t[12:11]];
				w[19:16] = {1'b0, t[10:8]};
				w[15:12] = {1'b0, t[10:8]};
				w[7:0]   = t[7:0];
			end
			FMT_ALU: begin
				w        = BASE_DP_REG_S;
				w[15:12] = {1'b0, rd3};
				case (aop)
					ALU_LSL: begin sh = SH_LSL; is_shift = 1'b1; end
					ALU_LSR: begin sh = SH_LSR; is_shift = 1'b1; end
					ALU_ASR: begin sh = SH_ASR; is_shift = 1'b1; end
					ALU_ROR: begin sh = SH_ROR; is_shift = 1'b1; end
					default: begin sh = SH_LSL; is_shift = 1'b0; end
				endcase
				if (aop == ALU_NEG) begin
					// RSBS Rd, Rs, #0
					w[25]    = 1'b1;
					w[24:21] = DP_RSB;
					w[19:16] = {1'b0, rs3};
				end else if (aop == ALU_MUL) begin
					// MULS Rd, Rs, Rd
					cls      = CLS_MUL;
					w[19:16] = {1'b0, rd3};
					w[11:8]  = {1'b0, rd3};
					w[7:4]   = MUL_MARK;
					w[3:0]   = {1'b0, rs3};
				end else if (is_shift) begin
					// MOVS Rd, Rd, <shift> Rs
					w[24:21] = DP_MOV;
					w[19:16] = {1'b0, rd3};
					w[11:8]  = {1'b0, rs3};
					w[6:5]   = sh;
					w[4]     = 1'b1;
					w[3:0]   = {1'b0, rd3};
				end else begin
					w[24:21] = aop;
					w[19:16] = {1'b0, rd3};
					w[3:0]   = {1'b0, rs3};
				end
			end
			FMT_HIREG: begin
				w        = BASE_DP_REG;
				w[19:16] = rd4;
				w[15:12] = rd4;
				w[3:0]   = rs4;
				case (t[9:8])
					HI_ADD: w[24:21] = DP_ADD;
					HI_CMP: begin
						w[24:21] = DP_CMP;
						w[20]    = 1'b1;
					end
					HI_MOV: w[24:21] = DP_MOV;
					default: begin
						// BX ignores the Rd bits
						cls    = CLS_BX;
						w      = BASE_BX;
						w[3:0] = rs4;
					end
				endcase
			end
			FMT_BCOND: begin
				cls = CLS_BRANCH;
				w   = {t[11:8], BCOND_OP, {16{t[7]}}, t[7:0]};
			end
			FMT_BAL: begin
				cls = CLS_BRANCH;
				w   = {BAL_TOP, {13{t[10]}}, t[10:0]};
			end
			default: begin
				w   = '0;
				cls = CLS_DP;
			end
		endcase

		dec.arm_word    = w;
		dec.instr_class = cls;
	end

	// Result port
	assign done = vld_s2;
	assign res  = out_s2;

endmodule
`default_nettype wire
